// ===== hw/rtl/icadm_pkg.sv =====
// ----------------------------------------------------------------------------
// icadm_pkg: shared definitions for the in-flight capacity admission gate
// Field widths, origin table size and operation/status codes.
// ----------------------------------------------------------------------------
package icadm_pkg;

   localparam int unsigned NumOrigins = 8;
   localparam int unsigned OriginIdxW = (NumOrigins > 1) ? $clog2(NumOrigins) : 1;

   localparam int unsigned FuncW    = 2;
   localparam int unsigned OriginW  = 3;
   localparam int unsigned ByteW    = 48;
   localparam int unsigned CountW   = 16;
   localparam int unsigned StatusW  = 2;
   localparam int unsigned CsrDataW = 64;
   localparam int unsigned CsrAddrW = 4;

   localparam logic [FuncW-1:0] FuncAcquire = 2'd0;
   localparam logic [FuncW-1:0] FuncRelease = 2'd1;
   localparam logic [FuncW-1:0] FuncLoad    = 2'd2;

   localparam logic [StatusW-1:0] StatusOk        = 2'd0;
   localparam logic [StatusW-1:0] StatusNoOrigin  = 2'd1;
   localparam logic [StatusW-1:0] StatusNoRoom    = 2'd2;
   localparam logic [StatusW-1:0] StatusUnderflow = 2'd3;

   localparam logic RegGlobalCount = 1'b0;
   localparam logic RegGlobalBytes = 1'b1;

endpackage

// ===== hw/rtl/inflight_capacity_admission.sv =====
// ----------------------------------------------------------------------------
// inflight_capacity_admission: credit-based admission gate for in-flight work
// Path: an accepted item passes the input register, then the result register;
//   the origin table read-modify-write sits between the two.
// Throughput: 1 item per cycle while the result is not stalled (rsp_stall).
// Reset: synchronous; clears origin enables, all usage counters and the
//   global limits; the block takes items in the first cycle after reset.
// ----------------------------------------------------------------------------
module inflight_capacity_admission (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [icadm_pkg::FuncW-1:0]             req_func,
   input  logic [icadm_pkg::OriginW-1:0]           req_origin,
   input  logic [icadm_pkg::ByteW-1:0]             req_byte_count,
   input  logic                                    req_entry_enable,
   input  logic [icadm_pkg::CountW-1:0]            req_entry_count_limit,
   input  logic [icadm_pkg::ByteW-1:0]             req_entry_byte_limit,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [icadm_pkg::StatusW-1:0]           rsp_status,
   output logic [icadm_pkg::ByteW-1:0]             rsp_inflight_bytes,
   output logic [icadm_pkg::CountW-1:0]            rsp_inflight_count,
   input  logic                                    psel,
   input  logic                                    penable,
   input  logic                                    pwrite,
   input  logic [icadm_pkg::CsrAddrW-1:0]          paddr,
   input  logic [icadm_pkg::CsrDataW-1:0]          pwdata,
   output logic [icadm_pkg::CsrDataW-1:0]          prdata,
   output logic                                    pready
);

   localparam int unsigned N  = icadm_pkg::NumOrigins;
   localparam int unsigned IW = icadm_pkg::OriginIdxW;
   localparam int unsigned BW = icadm_pkg::ByteW;
   localparam int unsigned CW = icadm_pkg::CountW;

   // configuration
   logic [CW-1:0] glb_cnt_lim_ff;
   logic [BW-1:0] glb_byte_lim_ff;
   logic          csr_wr;

   // input register
   logic                               in_valid_ff;
   logic [icadm_pkg::FuncW-1:0]        in_func_ff;
   logic [icadm_pkg::OriginW-1:0]      in_origin_ff;
   logic [BW-1:0]                      in_bytes_ff;
   logic                               in_en_ff;
   logic [CW-1:0]                      in_cnt_lim_ff;
   logic [BW-1:0]                      in_byte_lim_ff;
   logic                               req_accept;
   logic                               s1_adv;

   // origin table and totals
   logic [N-1:0]  org_en_ff;
   logic [CW-1:0] org_cnt_lim_ff  [N];
   logic [BW-1:0] org_byte_lim_ff [N];
   logic [CW-1:0] org_cnt_used_ff [N];
   logic [BW-1:0] org_bytes_used_ff [N];
   logic [CW-1:0] tot_cnt_ff;
   logic [BW-1:0] tot_bytes_ff;

   // result register
   logic                            out_valid_ff;
   logic [icadm_pkg::StatusW-1:0]   out_status_ff;
   logic [BW-1:0]                   out_bytes_ff;
   logic [CW-1:0]                   out_cnt_ff;

   // datapath
   logic [IW-1:0]                 idx;
   logic                          org_ok;
   logic                          org_on;
   logic [CW-1:0]                 o_cnt;
   logic [BW-1:0]                 o_bytes;
   logic [BW:0]                   tot_sum;
   logic [BW:0]                   org_sum;
   logic [BW:0]                   tot_diff;
   logic [BW:0]                   org_diff;
   logic                          bytes_zero;
   logic                          glb_fits;
   logic                          org_fits;
   logic                          tot_cnt_clamp;
   logic                          org_cnt_clamp;
   logic [icadm_pkg::StatusW-1:0] status_in;
   logic [CW-1:0]                 tot_cnt_in;
   logic [BW-1:0]                 tot_bytes_in;
   logic [CW-1:0]                 o_cnt_in;
   logic [BW-1:0]                 o_bytes_in;
   logic                          upd_used;
   logic                          upd_entry;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_comb begin
      unique case (paddr[3])
         icadm_pkg::RegGlobalCount: prdata = {{(icadm_pkg::CsrDataW-CW){1'b0}}, glb_cnt_lim_ff};
         icadm_pkg::RegGlobalBytes: prdata = {{(icadm_pkg::CsrDataW-BW){1'b0}}, glb_byte_lim_ff};
         default:                   prdata = '0;
      endcase
   end

   assign s1_adv     = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !s1_adv;
   assign req_accept = req_valid && !req_stall;

   assign rsp_valid          = out_valid_ff;
   assign rsp_status         = out_status_ff;
   assign rsp_inflight_bytes = out_bytes_ff;
   assign rsp_inflight_count = out_cnt_ff;

   assign idx        = in_origin_ff[IW-1:0];
   assign org_ok     = int'(in_origin_ff) < N;
   assign org_on     = org_ok && org_en_ff[idx];
   assign o_cnt      = org_cnt_used_ff[idx];
   assign o_bytes    = org_bytes_used_ff[idx];
   assign bytes_zero = (in_bytes_ff == '0);

   assign tot_sum  = {1'b0, tot_bytes_ff} + {1'b0, in_bytes_ff};
   assign org_sum  = {1'b0, o_bytes} + {1'b0, in_bytes_ff};
   assign tot_diff = {1'b0, tot_bytes_ff} - {1'b0, in_bytes_ff};
   assign org_diff = {1'b0, o_bytes} - {1'b0, in_bytes_ff};

   assign glb_fits = (tot_cnt_ff < glb_cnt_lim_ff)
                  && (bytes_zero || (tot_sum <= {1'b0, glb_byte_lim_ff}));
   assign org_fits = (o_cnt < org_cnt_lim_ff[idx])
                  && (bytes_zero || (org_sum <= {1'b0, org_byte_lim_ff[idx]}));

   assign tot_cnt_clamp = (tot_cnt_ff == '0);
   assign org_cnt_clamp = (o_cnt == '0);

   always_comb begin
      status_in    = icadm_pkg::StatusOk;
      tot_cnt_in   = tot_cnt_ff;
      tot_bytes_in = tot_bytes_ff;
      o_cnt_in     = o_cnt;
      o_bytes_in   = o_bytes;
      upd_used     = 1'b0;
      upd_entry    = 1'b0;
      case (in_func_ff)
         icadm_pkg::FuncAcquire: begin
            if (!org_on) begin
               status_in = icadm_pkg::StatusNoOrigin;
            end else if (!glb_fits || !org_fits) begin
               status_in = icadm_pkg::StatusNoRoom;
            end else begin
               upd_used     = 1'b1;
               tot_cnt_in   = tot_cnt_ff + 1'b1;
               tot_bytes_in = tot_sum[BW-1:0];
               o_cnt_in     = o_cnt + 1'b1;
               o_bytes_in   = org_sum[BW-1:0];
            end
         end
         icadm_pkg::FuncRelease: begin
            if (!org_on) begin
               status_in = icadm_pkg::StatusNoOrigin;
            end else begin
               upd_used     = 1'b1;
               tot_cnt_in   = tot_cnt_clamp ? '0 : tot_cnt_ff - 1'b1;
               tot_bytes_in = tot_diff[BW] ? '0 : tot_diff[BW-1:0];
               o_cnt_in     = org_cnt_clamp ? '0 : o_cnt - 1'b1;
               o_bytes_in   = org_diff[BW] ? '0 : org_diff[BW-1:0];
               if (tot_cnt_clamp || tot_diff[BW] || org_cnt_clamp || org_diff[BW]) begin
                  status_in = icadm_pkg::StatusUnderflow;
               end
            end
         end
         icadm_pkg::FuncLoad: begin
            if (!org_ok) begin
               status_in = icadm_pkg::StatusNoOrigin;
            end else begin
               upd_entry = 1'b1;
            end
         end
         default: begin
            status_in = icadm_pkg::StatusOk;
         end
      endcase
   end

   // control state, usage counters and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         org_en_ff       <= '0;
         tot_cnt_ff      <= '0;
         tot_bytes_ff    <= '0;
         glb_cnt_lim_ff  <= '0;
         glb_byte_lim_ff <= '0;
         for (int i = 0; i < N; i++) begin
            org_cnt_used_ff[i]   <= '0;
            org_bytes_used_ff[i] <= '0;
         end
      end else begin
         if (req_accept) begin
            in_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            in_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
         if (s1_adv && upd_used) begin
            tot_cnt_ff             <= tot_cnt_in;
            tot_bytes_ff           <= tot_bytes_in;
            org_cnt_used_ff[idx]   <= o_cnt_in;
            org_bytes_used_ff[idx] <= o_bytes_in;
         end
         if (s1_adv && upd_entry) begin
            org_en_ff[idx] <= in_en_ff;
         end
         if (csr_wr) begin
            unique case (paddr[3])
               icadm_pkg::RegGlobalCount: glb_cnt_lim_ff  <= pwdata[CW-1:0];
               icadm_pkg::RegGlobalBytes: glb_byte_lim_ff <= pwdata[BW-1:0];
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_func_ff     <= req_func;
         in_origin_ff   <= req_origin;
         in_bytes_ff    <= req_byte_count;
         in_en_ff       <= req_entry_enable;
         in_cnt_lim_ff  <= req_entry_count_limit;
         in_byte_lim_ff <= req_entry_byte_limit;
      end
      if (s1_adv) begin
         out_status_ff <= status_in;
         out_bytes_ff  <= tot_bytes_in;
         out_cnt_ff    <= tot_cnt_in;
      end
      if (s1_adv && upd_entry) begin
         org_cnt_lim_ff[idx]  <= in_cnt_lim_ff;
         org_byte_lim_ff[idx] <= in_byte_lim_ff;
      end
   end

   a_stall_when_full: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && rsp_stall) |-> req_stall)
      else $error("input stage not held while result stalled");

   a_grant_counts: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && in_func_ff == icadm_pkg::FuncAcquire && status_in == icadm_pkg::StatusOk)
      |=> (tot_cnt_ff == $past(tot_cnt_ff) + 1'b1))
      else $error("granted acquire did not raise the global count");

   a_refused_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && (status_in == icadm_pkg::StatusNoOrigin
                  || status_in == icadm_pkg::StatusNoRoom))
      |=> ($stable(tot_cnt_ff) && $stable(tot_bytes_ff)))
      else $error("refused item changed global usage");

   a_result_totals: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> (rsp_inflight_count == tot_cnt_ff && rsp_inflight_bytes == tot_bytes_ff))
      else $error("result totals differ from global usage");

endmodule
